@@ design/thruster_mixer_trim_deadband_defines.svh @@
// assertion macros shared by the checker
`ifndef THRUSTER_MIXER_TRIM_DEADBAND_DEFINES_SVH
`define THRUSTER_MIXER_TRIM_DEADBAND_DEFINES_SVH

// same-cycle implication, off during reset
`define TMTD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication failed");

// next-cycle implication, off during reset
`define TMTD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle implication failed");

`endif

@@ design/tmtd_pkg.sv @@
// shared constants, codes and control structs of the thruster mixer
`timescale 1ns / 1ps

package tmtd_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 16;
   localparam int NUM_AXES            = 6;
   localparam int NUM_THR             = 6;
   localparam int TRIM_WIDTH          = 16;
   localparam int TOL_WIDTH           = 15;
   localparam int TOL_FRAC            = 14;
   localparam int CSR_INDEX_WIDTH     = 3;
   localparam int CSR_DATA_WIDTH      = 16;

   localparam logic signed [TRIM_WIDTH-1:0] FORWARD_TRIM_RESET = -16'sd6554;
   localparam logic signed [TRIM_WIDTH-1:0] STRAFE_TRIM_RESET  = 16'sd4915;
   localparam logic signed [TRIM_WIDTH-1:0] PITCH_TRIM_RESET   = 16'sd1638;
   localparam logic [TOL_WIDTH-1:0]         TOLERANCE_RESET    = 15'd164;
   localparam logic signed [TRIM_WIDTH-1:0] TRIM_MAX           = 16'sd16384;
   localparam logic signed [TRIM_WIDTH-1:0] TRIM_MIN           = -16'sd16384;
   localparam int                           ROUND_HALF         = 8192;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_FORWARD_TRIM = 3'd0,
      CSR_STRAFE_TRIM  = 3'd1,
      CSR_PITCH_TRIM   = 3'd2,
      CSR_TOLERANCE    = 3'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      AX_YAW     = 3'd0,
      AX_FORWARD = 3'd1,
      AX_PITCH   = 3'd2,
      AX_DEPTH   = 3'd3,
      AX_STRAFE  = 3'd4,
      AX_ROLL    = 3'd5
   } axis_type;

   typedef enum logic [2:0] {
      THR_BOW       = 3'd0,
      THR_STERN     = 3'd1,
      THR_PORT      = 3'd2,
      THR_STARBOARD = 3'd3,
      THR_TOP       = 3'd4,
      THR_BOTTOM    = 3'd5
   } thruster_type;

   localparam logic [2:0] LAST_THRUSTER = 3'(NUM_THR - 1);

   typedef struct packed {
      logic       take;     // request transfer, clears the send mask
      logic       issue;    // load pipeline stage one for one thruster
      logic [2:0] idx;      // thruster issued
      logic       emit;     // load the result register
   } ctl_cmd_type;

   typedef struct packed {
      logic axis_ok;
      logic mask_any;
      logic out_free;
   } dp_status_type;

endpackage

@@ design/tmtd_if.sv @@
// request, result and register-write channels
`timescale 1ns / 1ps

interface tmtd_req_if #(parameter int VALUE_WIDTH = tmtd_pkg::VALUE_WIDTH_DEFAULT);
   logic                          valid;
   logic                          ready;
   logic [2:0]                    axis;
   logic signed [VALUE_WIDTH-1:0] request_value;

   modport source (output valid, axis, request_value, input ready);
   modport sink   (input valid, axis, request_value, output ready);
endinterface

interface tmtd_rsp_if #(parameter int VALUE_WIDTH = tmtd_pkg::VALUE_WIDTH_DEFAULT);
   logic                          valid;
   logic                          ready;
   logic [2:0]                    thruster;
   logic signed [VALUE_WIDTH-1:0] drive;
   logic                          last_of_run;

   modport source (output valid, thruster, drive, last_of_run, input ready);
   modport sink   (input valid, thruster, drive, last_of_run, output ready);
endinterface

interface tmtd_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [tmtd_pkg::CSR_INDEX_WIDTH-1:0]   index;
   logic [tmtd_pkg::CSR_DATA_WIDTH-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ design/thruster_mixer_trim_deadband.sv @@
// top level: thruster mixer with trims, clamp and update deadband
//
//   channel  dir  fields                           width
//   req_if   in   axis, request_value              3, VALUE_WIDTH
//   rsp_if   out  thruster, drive, last_of_run     3, VALUE_WIDTH, 1
//   csr_if   in   index, data                      3, 16
//
// one request at a time: it is accepted, its six thrusters pass through
// the shared two-stage mix/trim multiplier (one thruster per cycle), a
// drain state follows, and the results are then emitted in turn.
// synchronous active-high reset restores levels, trims and last drives.
// a result waiting in the output register never blocks the next request;
// a stall on rsp_if holds the emit sequence. csr_if is always ready.
`timescale 1ns / 1ps

module thruster_mixer_trim_deadband #(
   parameter int VALUE_WIDTH = tmtd_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   tmtd_req_if.sink   req_if,
   tmtd_rsp_if.source rsp_if,
   tmtd_csr_if.sink   csr_if
);

   tmtd_pkg::ctl_cmd_type   cmd;
   tmtd_pkg::dp_status_type status;

   assign csr_if.ready = 1'b1;

   tmtd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tmtd_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_axis     (req_if.axis),
      .req_value    (req_if.request_value),
      .csr_valid    (csr_if.valid),
      .csr_index    (csr_if.index),
      .csr_data     (csr_if.data),
      .rsp_valid    (rsp_if.valid),
      .rsp_ready    (rsp_if.ready),
      .rsp_thruster (rsp_if.thruster),
      .rsp_drive    (rsp_if.drive),
      .rsp_last     (rsp_if.last_of_run)
   );

endmodule

@@ design/tmtd_ctrl.sv @@
// sequencer: accept, issue six thrusters, drain, emit results
`timescale 1ns / 1ps

module tmtd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  tmtd_pkg::dp_status_type status,
   output tmtd_pkg::ctl_cmd_type   cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_MIX   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] idx_ff, idx_in;
   logic       take;

   assign req_ready = (state_ff == ST_IDLE);
   assign take      = req_valid && req_ready;

   always_comb begin
      cmd.take  = take;
      cmd.issue = (state_ff == ST_MIX);
      cmd.idx   = idx_ff;
      cmd.emit  = (state_ff == ST_EMIT) && status.mask_any && status.out_free;
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            // an unknown axis code leaves everything as it was
            if (take && status.axis_ok) begin
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            if (idx_ff == tmtd_pkg::LAST_THRUSTER) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + 3'd1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!status.mask_any) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

@@ design/tmtd_datapath.sv @@
// axis levels, trims, two-stage mix/trim/clamp pipe, send mask, result register
`timescale 1ns / 1ps

module tmtd_datapath #(
   parameter int VALUE_WIDTH = tmtd_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tmtd_pkg::ctl_cmd_type                cmd,
   output tmtd_pkg::dp_status_type              status,
   input  logic [2:0]                           req_axis,
   input  logic signed [VALUE_WIDTH-1:0]        req_value,
   input  logic                                 csr_valid,
   input  logic [tmtd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [tmtd_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [2:0]                           rsp_thruster,
   output logic signed [VALUE_WIDTH-1:0]        rsp_drive,
   output logic                                 rsp_last
);

   localparam int VW   = VALUE_WIDTH;
   localparam int FRAC = VW - 2;
   localparam int CW   = VW + 2;                      // mix and drive arithmetic
   localparam int PW   = VW + tmtd_pkg::TRIM_WIDTH;   // trim product
   localparam int TF   = tmtd_pkg::TOL_FRAC;
   localparam int NT   = tmtd_pkg::NUM_THR;

   localparam logic signed [CW-1:0] DRIVE_ONE  = CW'(1) << FRAC;
   localparam logic signed [CW-1:0] DRIVE_NEG  = -DRIVE_ONE;
   localparam logic signed [VW:0]   LAST_RESET = (VW + 1)'(1) << (FRAC + 1);

   // configuration
   logic signed [tmtd_pkg::TRIM_WIDTH-1:0] fwd_trim_ff, str_trim_ff, pit_trim_ff;
   logic [tmtd_pkg::TOL_WIDTH-1:0]         tol_ff;
   logic [CW-1:0]                          tol_scaled;

   // state
   logic signed [VW-1:0] level_ff [tmtd_pkg::NUM_AXES];
   logic signed [VW:0]   last_ff  [NT];
   logic [VW-1:0]        dbuf_ff  [NT];
   logic [NT-1:0]        mask_ff, mask_in;

   // stage one
   logic                 s1_valid_ff;
   logic [2:0]           s1_idx_ff;
   logic signed [CW-1:0] mix_ff, mix_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic                 apply_ff, apply_in;

   logic signed [VW-1:0]                   lv_a, lv_b, lv_t;
   logic                                   sub_sel, first_sel;
   logic signed [tmtd_pkg::TRIM_WIDTH-1:0] trim_sel;
   logic [tmtd_pkg::TRIM_WIDTH-1:0]        trim_mag;
   logic                                   trim_en;

   // stage two
   logic signed [PW-1:0] rnd;
   logic signed [CW-1:0] term, total, clamped, diff;
   logic [CW-1:0]        diff_abs;
   logic                 send;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           rsp_thr_ff;
   logic [VW-1:0]        rsp_drive_ff;
   logic                 rsp_last_ff;
   logic [NT-1:0]        pick, rest;
   logic [2:0]           pick_idx;

   // ---------------- configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_trim_ff <= tmtd_pkg::FORWARD_TRIM_RESET;
         str_trim_ff <= tmtd_pkg::STRAFE_TRIM_RESET;
         pit_trim_ff <= tmtd_pkg::PITCH_TRIM_RESET;
         tol_ff      <= tmtd_pkg::TOLERANCE_RESET;
      end else if (csr_valid) begin
         case (tmtd_pkg::csr_index_type'(csr_index))
            tmtd_pkg::CSR_FORWARD_TRIM: fwd_trim_ff <= csr_data;
            tmtd_pkg::CSR_STRAFE_TRIM:  str_trim_ff <= csr_data;
            tmtd_pkg::CSR_PITCH_TRIM:   pit_trim_ff <= csr_data;
            tmtd_pkg::CSR_TOLERANCE:    tol_ff      <= csr_data[tmtd_pkg::TOL_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // tolerance rescaled from unsigned q1.14 to the drive format
   generate
      if (FRAC >= TF) begin : g_tol_up
         assign tol_scaled = CW'(tol_ff) << (FRAC - TF);
      end else begin : g_tol_dn
         logic [tmtd_pkg::TOL_WIDTH-1:0] tol_sh;
         assign tol_sh     = tol_ff >> (TF - FRAC);
         assign tol_scaled = CW'(tol_sh);
      end
   endgenerate

   // ---------------- axis levels
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tmtd_pkg::NUM_AXES; i++) begin
            level_ff[i] <= '0;
         end
      end else if (cmd.take && status.axis_ok) begin
         level_ff[req_axis] <= req_value;
      end
   end

   // ---------------- stage one: pick operands, mix, trim product
   always_comb begin
      lv_a      = '0;
      lv_b      = '0;
      lv_t      = '0;
      sub_sel   = 1'b0;
      first_sel = 1'b0;
      trim_sel  = '0;
      case (tmtd_pkg::thruster_type'(cmd.idx))
         tmtd_pkg::THR_BOW: begin
            lv_a = level_ff[tmtd_pkg::AX_DEPTH];
            lv_b = level_ff[tmtd_pkg::AX_PITCH];
            sub_sel = 1'b1;
            lv_t = level_ff[tmtd_pkg::AX_DEPTH];
            trim_sel = pit_trim_ff;
         end
         tmtd_pkg::THR_STERN: begin
            lv_a = level_ff[tmtd_pkg::AX_DEPTH];
            lv_b = level_ff[tmtd_pkg::AX_PITCH];
            lv_t = level_ff[tmtd_pkg::AX_DEPTH];
            trim_sel = pit_trim_ff;
            first_sel = 1'b1;
         end
         tmtd_pkg::THR_PORT: begin
            lv_a = level_ff[tmtd_pkg::AX_FORWARD];
            lv_b = level_ff[tmtd_pkg::AX_YAW];
            lv_t = level_ff[tmtd_pkg::AX_FORWARD];
            trim_sel = fwd_trim_ff;
            first_sel = 1'b1;
         end
         tmtd_pkg::THR_STARBOARD: begin
            lv_a = level_ff[tmtd_pkg::AX_FORWARD];
            lv_b = level_ff[tmtd_pkg::AX_YAW];
            sub_sel = 1'b1;
            lv_t = level_ff[tmtd_pkg::AX_FORWARD];
            trim_sel = fwd_trim_ff;
         end
         tmtd_pkg::THR_TOP: begin
            lv_a = level_ff[tmtd_pkg::AX_ROLL];
            lv_b = level_ff[tmtd_pkg::AX_STRAFE];
            lv_t = level_ff[tmtd_pkg::AX_STRAFE];
            trim_sel = str_trim_ff;
            first_sel = 1'b1;
         end
         tmtd_pkg::THR_BOTTOM: begin
            lv_a = level_ff[tmtd_pkg::AX_ROLL];
            lv_b = level_ff[tmtd_pkg::AX_STRAFE];
            sub_sel = 1'b1;
            lv_t = level_ff[tmtd_pkg::AX_STRAFE];
            trim_sel = str_trim_ff;
         end
         default: ;
      endcase
   end

   // trims beyond one in magnitude are off; positive trims the second thruster
   assign trim_en  = (trim_sel <= tmtd_pkg::TRIM_MAX) && (trim_sel >= tmtd_pkg::TRIM_MIN);
   assign trim_mag = trim_sel[tmtd_pkg::TRIM_WIDTH-1] ? 16'(-trim_sel) : 16'(trim_sel);
   assign apply_in = trim_en && (first_sel ? (trim_sel < 0) : (trim_sel > 0));
   assign mix_in   = sub_sel ? (CW'(lv_a) - CW'(lv_b)) : (CW'(lv_a) + CW'(lv_b));
   assign prod_in  = PW'(lv_t)
                   * PW'($signed({1'b0, trim_mag[tmtd_pkg::TRIM_WIDTH-2:0]}));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         s1_idx_ff <= cmd.idx;
         mix_ff    <= mix_in;
         prod_ff   <= prod_in;
         apply_ff  <= apply_in;
      end
   end

   // ---------------- stage two: round, trim, clamp, deadband compare
   assign rnd   = prod_ff + PW'(tmtd_pkg::ROUND_HALF);
   assign term  = rnd[PW-1:TF];
   assign total = mix_ff - (apply_ff ? term : CW'(0));

   always_comb begin
      if (total > DRIVE_ONE) begin
         clamped = DRIVE_ONE;
      end else if (total < DRIVE_NEG) begin
         clamped = DRIVE_NEG;
      end else begin
         clamped = total;
      end
   end

   assign diff     = CW'(last_ff[s1_idx_ff]) - clamped;
   assign diff_abs = diff[CW-1] ? CW'(-diff) : CW'(diff);
   assign send     = s1_valid_ff && (diff_abs > tol_scaled);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NT; i++) begin
            last_ff[i] <= LAST_RESET;
         end
      end else if (send) begin
         last_ff[s1_idx_ff] <= (VW + 1)'(clamped);
      end
   end

   always_ff @(posedge clock) begin
      if (send) begin
         dbuf_ff[s1_idx_ff] <= clamped[VW-1:0];
      end
   end

   // ---------------- send mask and result register
   assign pick = mask_ff & (~mask_ff + NT'(1));
   assign rest = mask_ff & ~pick;

   always_comb begin
      pick_idx = '0;
      for (int i = 0; i < NT; i++) begin
         if (pick[i]) begin
            pick_idx = 3'(i);
         end
      end
   end

   always_comb begin
      mask_in = mask_ff;
      if (cmd.take) begin
         mask_in = '0;
      end else if (send) begin
         mask_in[s1_idx_ff] = 1'b1;
      end else if (cmd.emit) begin
         mask_in = rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_thr_ff   <= pick_idx;
         rsp_drive_ff <= dbuf_ff[pick_idx];
         rsp_last_ff  <= (rest == '0);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_thruster = rsp_thr_ff;
   assign rsp_drive    = rsp_drive_ff;
   assign rsp_last     = rsp_last_ff;

   always_comb begin
      status.axis_ok  = (req_axis < 3'(tmtd_pkg::NUM_AXES));
      status.mask_any = |mask_ff;
      status.out_free = !rsp_valid_ff || rsp_ready;
   end

endmodule

@@ design/tmtd_checker.sv @@
// port-level checks on the thruster mixer and their bind
`timescale 1ns / 1ps
`include "thruster_mixer_trim_deadband_defines.svh"

module tmtd_checker #(
   parameter int VALUE_WIDTH = tmtd_pkg::VALUE_WIDTH_DEFAULT
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [2:0]                    req_axis,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [2:0]                    rsp_thruster,
   input logic signed [VALUE_WIDTH-1:0] rsp_drive,
   input logic                          rsp_last
);

   localparam logic signed [VALUE_WIDTH-1:0] DRIVE_ONE = VALUE_WIDTH'(1) << (VALUE_WIDTH - 2);
   localparam logic [2:0]                    AXIS_LIMIT = 3'(tmtd_pkg::NUM_AXES);

   // a stalled result keeps its contents
   `TMTD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_thruster) && $stable(rsp_drive) && $stable(rsp_last))

   // drives stay inside minus one to one
   `TMTD_ASSERT_IMPL(a_drive_range, clock, reset, rsp_valid, (rsp_drive <= DRIVE_ONE) && (rsp_drive >= -DRIVE_ONE))

   // a known axis starts a run, so no request is taken next cycle
   `TMTD_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready && (req_axis < AXIS_LIMIT), !req_ready)

   // more results of the run follow, so the request side stays closed
   `TMTD_ASSERT_NEXT(a_busy_mid_run, clock, reset, rsp_valid && rsp_ready && !rsp_last, !req_ready)

endmodule

bind thruster_mixer_trim_deadband tmtd_checker #(
   .VALUE_WIDTH (VALUE_WIDTH)
) u_tmtd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .req_axis     (req_if.axis),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_thruster (rsp_if.thruster),
   .rsp_drive    (rsp_if.drive),
   .rsp_last     (rsp_if.last_of_run)
);

@@ tb/tb_thruster_mixer_trim_deadband.sv @@
// self-checking testbench for the thruster mixer: scoreboard against an in-bench mixer
`timescale 1ns / 1ps

module tb_thruster_mixer_trim_deadband;

   localparam int VW            = tmtd_pkg::VALUE_WIDTH_DEFAULT;
   localparam int IDLE_LIMIT    = 4000;
   localparam int SETTLE_CYCLES = 24;
   localparam int TRIM_FRAC     = 14;
   localparam int LEVEL_ONE     = 1 << (VW - 2);
   localparam int TW            = tmtd_pkg::TRIM_WIDTH;

   localparam logic [2:0] AXIS_SPARE_LO = 3'd6;
   localparam logic [2:0] AXIS_SPARE_HI = 3'd7;
   localparam logic [tmtd_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE = 3'd7;

   localparam logic signed [VW-1:0] LEVEL_MAX = {1'b0, {(VW-1){1'b1}}};
   localparam logic signed [VW-1:0] LEVEL_MIN = {1'b1, {(VW-1){1'b0}}};

   typedef struct {
      logic [2:0]             axis;
      logic signed [VW-1:0]   level;
      bit                     hold;   // wait for all drive updates before sending
   } axis_cmd_type;

   typedef struct {
      logic [2:0]             thruster;
      logic signed [VW-1:0]   drive;
      logic                   last_of_run;
   } drive_update_type;

   logic clock;
   logic reset;

   tmtd_req_if #(.VALUE_WIDTH(VW)) req_if ();
   tmtd_rsp_if #(.VALUE_WIDTH(VW)) rsp_if ();
   tmtd_csr_if                     csr_if ();

   thruster_mixer_trim_deadband #(.VALUE_WIDTH(VW)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source),
      .csr_if (csr_if.sink)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // mixer state as the block should hold it
   logic signed [VW-1:0]                  axis_level [tmtd_pkg::NUM_AXES];
   longint                                last_drive [tmtd_pkg::NUM_THR];
   longint                                mix_drive  [tmtd_pkg::NUM_THR];
   logic signed [TW-1:0]                  trim_fwd;
   logic signed [TW-1:0]                  trim_strafe;
   logic signed [TW-1:0]                  trim_pitch;
   logic [tmtd_pkg::TOL_WIDTH-1:0]        tolerance;

   logic signed [VW-1:0] plan_level [tmtd_pkg::NUM_AXES];

   axis_cmd_type     cmd_q [$];
   drive_update_type drive_updates_q [$];

   int  queued_items   = 0;
   int  accepted_items = 0;
   int  errors         = 0;
   int  idle_cycles    = 0;
   int  req_idle_pct   = 0;
   int  rsp_stall_pct  = 0;
   logic req_taken;

   function automatic void reset_mixer();
      for (int i = 0; i < tmtd_pkg::NUM_AXES; i++) begin
         axis_level[i] = '0;
         plan_level[i] = '0;
      end
      for (int i = 0; i < tmtd_pkg::NUM_THR; i++) begin
         last_drive[i] = longint'(2) << (VW - 2);
      end
      trim_fwd    = tmtd_pkg::FORWARD_TRIM_RESET;
      trim_strafe = tmtd_pkg::STRAFE_TRIM_RESET;
      trim_pitch  = tmtd_pkg::PITCH_TRIM_RESET;
      tolerance   = tmtd_pkg::TOLERANCE_RESET;
   endfunction

   // positive trim pulls the second thruster, negative the first
   function automatic void trim_pair(int first, int second, longint level,
                                     logic signed [TW-1:0] t);
      longint mag;
      longint amount;
      if (t > tmtd_pkg::TRIM_MAX || t < tmtd_pkg::TRIM_MIN || t == 0) return;
      mag = (t < 0) ? -longint'(t) : longint'(t);
      amount = (level * mag + tmtd_pkg::ROUND_HALF) >>> TRIM_FRAC;
      if (t > 0) begin
         mix_drive[second] -= amount;
      end else begin
         mix_drive[first] -= amount;
      end
   endfunction

   function automatic void mix_thrusters(logic [2:0] ax, logic signed [VW-1:0] level);
      longint yaw, fwd, pitch, depth, strafe, roll, d, diff;
      int first_new;
      drive_update_type u;
      if (ax > tmtd_pkg::AX_ROLL) return;
      axis_level[ax] = level;
      yaw    = axis_level[tmtd_pkg::AX_YAW];
      fwd    = axis_level[tmtd_pkg::AX_FORWARD];
      pitch  = axis_level[tmtd_pkg::AX_PITCH];
      depth  = axis_level[tmtd_pkg::AX_DEPTH];
      strafe = axis_level[tmtd_pkg::AX_STRAFE];
      roll   = axis_level[tmtd_pkg::AX_ROLL];
      mix_drive[tmtd_pkg::THR_BOW]       = depth - pitch;
      mix_drive[tmtd_pkg::THR_STERN]     = depth + pitch;
      mix_drive[tmtd_pkg::THR_PORT]      = fwd + yaw;
      mix_drive[tmtd_pkg::THR_STARBOARD] = fwd - yaw;
      mix_drive[tmtd_pkg::THR_TOP]       = roll + strafe;
      mix_drive[tmtd_pkg::THR_BOTTOM]    = roll - strafe;
      trim_pair(tmtd_pkg::THR_PORT, tmtd_pkg::THR_STARBOARD, fwd, trim_fwd);
      trim_pair(tmtd_pkg::THR_TOP, tmtd_pkg::THR_BOTTOM, strafe, trim_strafe);
      trim_pair(tmtd_pkg::THR_STERN, tmtd_pkg::THR_BOW, depth, trim_pitch);
      first_new = drive_updates_q.size();
      for (int i = 0; i < tmtd_pkg::NUM_THR; i++) begin
         d = mix_drive[i];
         if (d > LEVEL_ONE) d = LEVEL_ONE;
         if (d < -LEVEL_ONE) d = -LEVEL_ONE;
         diff = last_drive[i] - d;
         if (diff < 0) diff = -diff;
         // change equal to the tolerance is held back
         if (diff > longint'(tolerance)) begin
            last_drive[i] = d;
            u.thruster    = 3'(i);
            u.drive       = VW'(d);
            u.last_of_run = 1'b0;
            drive_updates_q.push_back(u);
         end
      end
      if (drive_updates_q.size() > first_new) begin
         drive_updates_q[drive_updates_q.size() - 1].last_of_run = 1'b1;
      end
   endfunction

   function automatic axis_cmd_type random_cmd();
      axis_cmd_type c;
      c.hold = 1'b0;
      if ($urandom_range(19) == 0) begin
         c.axis  = 3'($urandom_range(AXIS_SPARE_LO, AXIS_SPARE_HI));
         c.level = VW'($urandom);
         return c;
      end
      c.axis = 3'($urandom_range(tmtd_pkg::NUM_AXES - 1));
      case ($urandom_range(9))
         0: c.level = VW'($urandom);
         1: begin
            case ($urandom_range(4))
               0: c.level = LEVEL_MIN;
               1: c.level = LEVEL_MAX;
               2: c.level = VW'(LEVEL_ONE);
               3: c.level = VW'(-LEVEL_ONE);
               default: c.level = '0;
            endcase
         end
         2, 3, 4, 5: c.level = VW'(int'($urandom_range(2 * LEVEL_ONE)) - LEVEL_ONE);
         6, 7, 8: c.level = plan_level[c.axis] + VW'(int'($urandom_range(400)) - 200);
         default: c.level = plan_level[c.axis];
      endcase
      plan_level[c.axis] = c.level;
      return c;
   endfunction

   function automatic void queue_cmd(axis_cmd_type c);
      cmd_q.push_back(c);
      queued_items++;
   endfunction

   function automatic void queue_axis(logic [2:0] ax, logic signed [VW-1:0] level);
      axis_cmd_type c;
      c.axis  = ax;
      c.level = level;
      c.hold  = 1'b0;
      queue_cmd(c);
   endfunction

   task automatic write_reg(logic [tmtd_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            logic [tmtd_pkg::CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         tmtd_pkg::CSR_FORWARD_TRIM: trim_fwd    = value;
         tmtd_pkg::CSR_STRAFE_TRIM:  trim_strafe = value;
         tmtd_pkg::CSR_PITCH_TRIM:   trim_pitch  = value;
         tmtd_pkg::CSR_TOLERANCE:    tolerance   = value[tmtd_pkg::TOL_WIDTH-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // all requests taken, all updates seen, then room for a zero-update request to finish
   task automatic wait_idle();
      do @(negedge clock);
      while (accepted_items < queued_items || drive_updates_q.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_random(int idle_pct, int stall_pct, int count);
      axis_cmd_type c;
      int n;
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      n = 0;
      while (n < count) begin
         c = random_cmd();
         if (n == 10) c.hold = 1'b1;
         queue_cmd(c);
         if (c.axis <= tmtd_pkg::AX_ROLL) n++;
      end
      wait_idle();
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (cmd_q.size() != 0 && !(cmd_q[0].hold && drive_updates_q.size() != 0)
             && $urandom_range(99) >= req_idle_pct) begin
            req_if.valid         <= 1'b1;
            req_if.axis          <= cmd_q[0].axis;
            req_if.request_value <= cmd_q[0].level;
            void'(cmd_q.pop_front());
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_if.ready <= !reset && ($urandom_range(99) >= rsp_stall_pct);
   end

   // transfer monitor, drive update checker and watchdog
   always @(posedge clock) begin : monitor
      drive_update_type want;
      if (reset) begin
         req_taken   <= 1'b0;
         idle_cycles <= 0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            mix_thrusters(req_if.axis, req_if.request_value);
            accepted_items++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (drive_updates_q.size() == 0) begin
               $display("%0t: unexpected update: thruster %0d drive %0d last %0b",
                        $time, rsp_if.thruster, rsp_if.drive, rsp_if.last_of_run);
               errors++;
            end else begin
               want = drive_updates_q.pop_front();
               if (rsp_if.thruster !== want.thruster) begin
                  $display("%0t: thruster expected %0d actual %0d",
                           $time, want.thruster, rsp_if.thruster);
                  errors++;
               end
               if (rsp_if.drive !== want.drive) begin
                  $display("%0t: drive of thruster %0d expected %0d actual %0d",
                           $time, want.thruster, want.drive, rsp_if.drive);
                  errors++;
               end
               if (rsp_if.last_of_run !== want.last_of_run) begin
                  $display("%0t: last_of_run of thruster %0d expected %0b actual %0b",
                           $time, want.thruster, want.last_of_run, rsp_if.last_of_run);
                  errors++;
               end
            end
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
             || (csr_if.valid && csr_if.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("tb_thruster_mixer_trim_deadband: errors");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.axis          = '0;
      req_if.request_value = '0;
      rsp_if.ready         = 1'b0;
      csr_if.valid         = 1'b0;
      csr_if.index         = '0;
      csr_if.data          = '0;
      reset_mixer();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: first mix sends all, field extremes, spare axis codes
      queue_axis(tmtd_pkg::AX_YAW, '0);
      queue_axis(tmtd_pkg::AX_YAW, LEVEL_MAX);
      queue_axis(tmtd_pkg::AX_YAW, LEVEL_MIN);
      queue_axis(tmtd_pkg::AX_FORWARD, VW'(LEVEL_ONE));
      queue_axis(tmtd_pkg::AX_FORWARD, VW'(-LEVEL_ONE));
      queue_axis(tmtd_pkg::AX_PITCH, LEVEL_MAX);
      queue_axis(tmtd_pkg::AX_DEPTH, LEVEL_MIN);
      queue_axis(tmtd_pkg::AX_STRAFE, VW'(LEVEL_ONE));
      queue_axis(tmtd_pkg::AX_STRAFE, LEVEL_MIN);
      queue_axis(tmtd_pkg::AX_ROLL, LEVEL_MAX);
      queue_axis(tmtd_pkg::AX_ROLL, -16'sd1);
      queue_axis(AXIS_SPARE_LO, LEVEL_MAX);
      queue_axis(AXIS_SPARE_HI, -16'sd1);
      // deadband edge: a change of exactly the tolerance stays quiet
      queue_axis(tmtd_pkg::AX_FORWARD, '0);
      queue_axis(tmtd_pkg::AX_YAW, 16'sd1000);
      queue_axis(tmtd_pkg::AX_YAW, 16'sd1000 + 16'(tmtd_pkg::TOLERANCE_RESET));
      queue_axis(tmtd_pkg::AX_YAW, 16'sd1001 + 16'(tmtd_pkg::TOLERANCE_RESET));
      queue_axis(tmtd_pkg::AX_YAW, 16'sd1001 + 16'(tmtd_pkg::TOLERANCE_RESET));
      queue_axis(tmtd_pkg::AX_PITCH, '0);
      queue_axis(tmtd_pkg::AX_DEPTH, VW'(LEVEL_ONE));
      queue_axis(tmtd_pkg::AX_DEPTH, -16'sd1);
      queue_axis(tmtd_pkg::AX_STRAFE, VW'(-LEVEL_ONE));
      for (int i = 0; i < tmtd_pkg::NUM_AXES; i++) plan_level[i] = axis_level[i];
      wait_idle();
      for (int i = 0; i < tmtd_pkg::NUM_AXES; i++) plan_level[i] = axis_level[i];

      write_reg(tmtd_pkg::CSR_FORWARD_TRIM, 16'(tmtd_pkg::TRIM_MAX));
      write_reg(tmtd_pkg::CSR_STRAFE_TRIM, 16'(tmtd_pkg::TRIM_MIN));
      write_reg(tmtd_pkg::CSR_PITCH_TRIM, '0);
      write_reg(tmtd_pkg::CSR_TOLERANCE, '0);
      write_reg(CSR_SPARE, 16'hFFFF);
      run_random(0, 0, 30);

      // trims just past one are switched off
      write_reg(tmtd_pkg::CSR_FORWARD_TRIM, 16'sd16385);
      write_reg(tmtd_pkg::CSR_STRAFE_TRIM, -16'sd16385);
      write_reg(tmtd_pkg::CSR_PITCH_TRIM, 16'(LEVEL_MIN));
      write_reg(tmtd_pkg::CSR_TOLERANCE, 16'hFFFF);
      run_random(79, 0, 30);

      write_reg(tmtd_pkg::CSR_FORWARD_TRIM,
                16'(int'($urandom_range(2 * LEVEL_ONE)) - LEVEL_ONE));
      write_reg(tmtd_pkg::CSR_STRAFE_TRIM, 16'(LEVEL_MAX));
      write_reg(tmtd_pkg::CSR_PITCH_TRIM, 16'(tmtd_pkg::TRIM_MAX));
      write_reg(tmtd_pkg::CSR_TOLERANCE, 16'($urandom_range(300)));
      run_random(0, 79, 30);

      write_reg(tmtd_pkg::CSR_FORWARD_TRIM, 16'(tmtd_pkg::TRIM_MIN));
      write_reg(tmtd_pkg::CSR_STRAFE_TRIM, 16'($urandom));
      write_reg(tmtd_pkg::CSR_PITCH_TRIM,
                16'(int'($urandom_range(2 * LEVEL_ONE)) - LEVEL_ONE));
      write_reg(tmtd_pkg::CSR_TOLERANCE, 16'($urandom_range(200)));
      run_random(10, 10, 30);

      write_reg(tmtd_pkg::CSR_FORWARD_TRIM, 16'(LEVEL_MIN));
      write_reg(tmtd_pkg::CSR_STRAFE_TRIM, '0);
      write_reg(tmtd_pkg::CSR_PITCH_TRIM, 16'(tmtd_pkg::TRIM_MIN));
      write_reg(tmtd_pkg::CSR_TOLERANCE, 16'(LEVEL_ONE));
      run_random(0, 0, 12);

      if (errors == 0) begin
         $display("tb_thruster_mixer_trim_deadband: clean");
      end else begin
         $display("tb_thruster_mixer_trim_deadband: errors");
      end
      $finish;
   end

endmodule

@@ thruster_mixer_trim_deadband.f @@
+incdir+design
design/tmtd_pkg.sv
design/tmtd_if.sv
design/tmtd_ctrl.sv
design/tmtd_datapath.sv
design/thruster_mixer_trim_deadband.sv
design/tmtd_checker.sv
tb/tb_thruster_mixer_trim_deadband.sv
